/* sv/cpyc_pkg.sv */
// ----------------------------------------------------------------------------
// cpyc_pkg
// Shared constants and types of the cascaded PI yaw controller.
// ----------------------------------------------------------------------------
package cpyc_pkg;

  localparam int ACC_W  = 36;  // product accumulator
  localparam int FRAC_W = 12;  // Q4.12 gains
  localparam int GAIN_W = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [13:0] WRAP_HALF = 14'sd2880;
  localparam logic signed [13:0] WRAP_FULL = 14'sd5760;
  localparam logic signed [23:0] RATE_SAT  = 24'sd32767;
  localparam logic signed [23:0] DZ_THRESH = 24'sd2;

  localparam logic [15:0] RST_OUTER_PROP = 16'd26829;
  localparam logic [15:0] RST_OUTER_INT  = 16'd123;
  localparam logic [15:0] RST_INNER_PROP = 16'd1843;
  localparam logic [15:0] RST_INNER_INT  = 16'd102;
  localparam logic [14:0] RST_ANGLE_LIM  = 15'd4800;
  localparam logic [14:0] RST_RATE_LIM   = 15'd1280;
  localparam logic [7:0]  RST_DEADZONE   = 8'd16;
  localparam logic [9:0]  RST_PWM_LIM    = 10'd200;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_PROP = 4'd0,
    REG_OUTER_INT  = 4'd1,
    REG_INNER_PROP = 4'd2,
    REG_INNER_INT  = 4'd3,
    REG_ANGLE_LIM  = 4'd4,
    REG_RATE_LIM   = 4'd5,
    REG_DEADZONE   = 4'd6,
    REG_PWM_LIM    = 4'd7
  } cfg_reg_t;

endpackage

/* sv/cascaded_pi_yaw_controller_unit.sv */
// ----------------------------------------------------------------------------
// cascaded_pi_yaw_controller_unit
// Cascaded PI heading/rate controller driving two wheel PWM values.
//
// Input channel (in_valid/in_ready) takes one sample word: fwd_speed,
// target_heading, measured_heading, measured_rate. Output channel
// (out_valid/out_ready) returns one word per sample: left_pwm, right_pwm.
// Config port: cfg_we writes cfg_data into register cfg_index on the clock
// edge; indexes past the last register are ignored. Write only while idle.
//
// One sample is handled at a time. The four gain products share one
// shift-and-add multiplier that consumes one gain bit per cycle. Five steps
// surround them: heading error, rate error, rate integrator, turn and output.
// in_ready returns in the same cycle as the result word appears, so a new
// sample is taken only once the last result is in the output register.
// The output register decouples the sides: if the receiver stalls, the
// finished word waits there and the next sample still runs, then holds in
// its last step until the register is free.
// Synchronous reset clears both integrators, restores the register defaults
// and empties the output register.
// ----------------------------------------------------------------------------
module cascaded_pi_yaw_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [10:0]                  fwd_speed,
  input  logic signed [12:0]                  target_heading,
  input  logic signed [12:0]                  measured_heading,
  input  logic signed [15:0]                  measured_rate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [10:0]                  left_pwm,
  output logic signed [10:0]                  right_pwm,
  input  logic                                cfg_we,
  input  logic [cpyc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpyc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_MUL_OUTER, S_RATE, S_RINT, S_MUL_INNER, S_TURN, S_OUT
  } state_t;

  state_t state;

  // config registers
  logic [15:0] outer_prop_gain, outer_int_gain, inner_prop_gain, inner_int_gain;
  logic [14:0] angle_integral_limit, rate_integral_limit;
  logic [7:0]  deadzone_offset;
  logic [9:0]  pwm_limit;

  // state and working registers
  logic signed [15:0] heading_integral, rate_integral;
  logic signed [13:0] err;
  logic signed [10:0] base;
  logic signed [15:0] rate;
  logic signed [16:0] rate_err;
  logic signed [20:0] turn;
  cpyc_pkg::acc_t     acc, mcand;
  logic [cpyc_pkg::GAIN_W-1:0] gain_sr;
  logic [4:0]         cnt;

  // heading error with wrap
  logic signed [13:0] err_diff, err_wrap;
  always_comb begin
    err_diff = 14'(target_heading) - 14'(measured_heading);
    err_wrap = err_diff;
    if (err_wrap > cpyc_pkg::WRAP_HALF) err_wrap = err_wrap - cpyc_pkg::WRAP_FULL;
    if (err_wrap < -cpyc_pkg::WRAP_HALF) err_wrap = err_wrap + cpyc_pkg::WRAP_FULL;
  end

  // heading integrator
  logic signed [16:0] hi_sum, hi_lim;
  logic signed [15:0] heading_integral_next;
  always_comb begin
    hi_sum = 17'(heading_integral) + 17'(err);
    hi_lim = $signed({2'b00, angle_integral_limit});
    if (hi_sum > hi_lim)       heading_integral_next = hi_lim[15:0];
    else if (hi_sum < -hi_lim) heading_integral_next = 16'(-hi_lim);
    else                       heading_integral_next = hi_sum[15:0];
  end

  // desired rate and rate error
  logic signed [23:0] prod_hi;
  logic signed [15:0] d_sat;
  logic signed [16:0] rate_err_next;
  always_comb begin
    prod_hi = acc[cpyc_pkg::ACC_W-1:cpyc_pkg::FRAC_W];
    if (prod_hi > cpyc_pkg::RATE_SAT)       d_sat = cpyc_pkg::RATE_SAT[15:0];
    else if (prod_hi < -cpyc_pkg::RATE_SAT) d_sat = 16'(-cpyc_pkg::RATE_SAT);
    else                                    d_sat = prod_hi[15:0];
    rate_err_next = 17'(d_sat) - 17'(rate);
  end

  // rate integrator
  logic signed [17:0] ri_sum, ri_lim;
  logic signed [15:0] rate_integral_next;
  always_comb begin
    ri_sum = 18'(rate_integral) + 18'(rate_err);
    ri_lim = $signed({3'b000, rate_integral_limit});
    if (ri_sum > ri_lim)       rate_integral_next = ri_lim[15:0];
    else if (ri_sum < -ri_lim) rate_integral_next = 16'(-ri_lim);
    else                       rate_integral_next = ri_sum[15:0];
  end

  // dead zone and reduction to whole counts
  logic signed [24:0] t16_adj, dz16;
  logic signed [20:0] turn_next;
  always_comb begin
    dz16 = $signed({13'd0, deadzone_offset, 4'd0});
    if (prod_hi >= cpyc_pkg::DZ_THRESH)       t16_adj = 25'(prod_hi) + dz16;
    else if (prod_hi <= -cpyc_pkg::DZ_THRESH) t16_adj = 25'(prod_hi) - dz16;
    else                                      t16_adj = 25'(prod_hi);
    turn_next = t16_adj[24:4];
  end

  // wheel outputs
  logic signed [21:0] left_sum, right_sum, plim;
  logic signed [10:0] left_next, right_next;
  always_comb begin
    plim      = $signed({12'd0, pwm_limit});
    left_sum  = 22'(base) - 22'(turn);
    right_sum = 22'(base) + 22'(turn);
    if (left_sum > plim)       left_next = plim[10:0];
    else if (left_sum < -plim) left_next = 11'(-plim);
    else                       left_next = left_sum[10:0];
    if (right_sum > plim)       right_next = plim[10:0];
    else if (right_sum < -plim) right_next = 11'(-plim);
    else                        right_next = right_sum[10:0];
  end

  assign in_ready = (state == S_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_prop_gain      <= cpyc_pkg::RST_OUTER_PROP;
      outer_int_gain       <= cpyc_pkg::RST_OUTER_INT;
      inner_prop_gain      <= cpyc_pkg::RST_INNER_PROP;
      inner_int_gain       <= cpyc_pkg::RST_INNER_INT;
      angle_integral_limit <= cpyc_pkg::RST_ANGLE_LIM;
      rate_integral_limit  <= cpyc_pkg::RST_RATE_LIM;
      deadzone_offset      <= cpyc_pkg::RST_DEADZONE;
      pwm_limit            <= cpyc_pkg::RST_PWM_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        cpyc_pkg::REG_OUTER_PROP: outer_prop_gain      <= cfg_data;
        cpyc_pkg::REG_OUTER_INT:  outer_int_gain       <= cfg_data;
        cpyc_pkg::REG_INNER_PROP: inner_prop_gain      <= cfg_data;
        cpyc_pkg::REG_INNER_INT:  inner_int_gain       <= cfg_data;
        cpyc_pkg::REG_ANGLE_LIM:  angle_integral_limit <= cfg_data[14:0];
        cpyc_pkg::REG_RATE_LIM:   rate_integral_limit  <= cfg_data[14:0];
        cpyc_pkg::REG_DEADZONE:   deadzone_offset      <= cfg_data[7:0];
        cpyc_pkg::REG_PWM_LIM:    pwm_limit            <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer, serial multiplier and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      heading_integral <= '0;
      rate_integral    <= '0;
      cnt              <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            err   <= err_wrap;
            base  <= fwd_speed;
            rate  <= measured_rate;
            state <= S_ERR;
          end
        end
        S_ERR: begin
          heading_integral <= heading_integral_next;
          acc     <= '0;
          mcand   <= cpyc_pkg::acc_t'(err);
          gain_sr <= outer_prop_gain;
          cnt     <= '0;
          state   <= S_MUL_OUTER;
        end
        S_MUL_OUTER, S_MUL_INNER: begin
          if (gain_sr[0]) acc <= acc + mcand;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            if (state == S_MUL_OUTER) begin
              mcand   <= cpyc_pkg::acc_t'(heading_integral);
              gain_sr <= outer_int_gain;
            end else begin
              mcand   <= cpyc_pkg::acc_t'(rate_integral);
              gain_sr <= inner_int_gain;
            end
          end else begin
            gain_sr <= gain_sr >> 1;
            mcand   <= mcand <<< 1;
          end
          if (cnt == 5'd31) state <= (state == S_MUL_OUTER) ? S_RATE : S_TURN;
        end
        S_RATE: begin
          rate_err <= rate_err_next;
          state    <= S_RINT;
        end
        S_RINT: begin
          rate_integral <= rate_integral_next;
          acc     <= '0;
          mcand   <= cpyc_pkg::acc_t'(rate_err);
          gain_sr <= inner_prop_gain;
          cnt     <= '0;
          state   <= S_MUL_INNER;
        end
        S_TURN: begin
          turn  <= turn_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            left_pwm  <= left_next;
            right_pwm <= right_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/cpyc_checker.sv */
// ----------------------------------------------------------------------------
// cpyc_checker
// Port-level checks of the yaw controller, bound to the top level.
// ----------------------------------------------------------------------------
module cpyc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic signed [10:0]              fwd_speed,
  input logic signed [12:0]              target_heading,
  input logic signed [12:0]              measured_heading,
  input logic signed [15:0]              measured_rate,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [10:0]              left_pwm,
  input logic signed [10:0]              right_pwm,
  input logic                            cfg_we,
  input logic [cpyc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cpyc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_pwm) && $stable(right_pwm))
    else $error("output word changed while stalled");

  // one sample in flight at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // clamp never yields the most negative code
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_pwm != -11'sd1024 && right_pwm != -11'sd1024)
    else $error("pwm out of range");

endmodule

bind cascaded_pi_yaw_controller_unit cpyc_checker u_cpyc_checker (.*);

/* dv/cpyc_yaw_checker.sv */
// ----------------------------------------------------------------------------
// cpyc_yaw_checker
// Predicts and checks the wheel drive words of the cascaded PI yaw controller.
//
// Follows the register writes and every accepted sample word, runs its own
// copy of the heading and rate integrators, queues the expected left/right
// drive word and compares it field by field with each accepted result word.
// ----------------------------------------------------------------------------
module cpyc_yaw_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [10:0]                 fwd_speed,
  input  logic signed [12:0]                 target_heading,
  input  logic signed [12:0]                 measured_heading,
  input  logic signed [15:0]                 measured_rate,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [10:0]                 left_pwm,
  input  logic signed [10:0]                 right_pwm,
  input  logic                               cfg_we,
  input  logic [cpyc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpyc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 words_checked
);

  localparam longint HALF_TURN    = 2880;
  localparam longint FULL_TURN    = 5760;
  localparam longint RATE_CMD_MAX = 32767;
  localparam longint DZ_MIN_TURN  = 2;

  typedef struct packed {
    logic signed [10:0] left_pwm;
    logic signed [10:0] right_pwm;
  } wheel_word_t;

  wheel_word_t wheel_q[$];

  logic [15:0] outer_kp, outer_ki, inner_kp, inner_ki;
  int          angle_lim, rate_lim, dz_counts, pwm_lim;
  int          heading_acc, rate_acc;
  int          bad_count = 0;
  int          good_count = 0;

  function automatic longint clamp_sym(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Advances both integrators and returns the drive word for one sample.
  function automatic wheel_word_t predict_wheels(input logic signed [10:0] base,
                                                 input logic signed [12:0] tgt,
                                                 input logic signed [12:0] meas,
                                                 input logic signed [15:0] yaw_rate);
    longint      err, rate_cmd, rate_err, turn16, turn;
    wheel_word_t w;
    err = longint'(tgt) - longint'(meas);
    if (err > HALF_TURN) err -= FULL_TURN;
    if (err < -HALF_TURN) err += FULL_TURN;
    heading_acc = int'(clamp_sym(heading_acc + err, angle_lim));
    rate_cmd = (longint'(outer_kp) * err + longint'(outer_ki) * heading_acc) >>> 12;
    rate_cmd = clamp_sym(rate_cmd, RATE_CMD_MAX);
    rate_err = rate_cmd - longint'(yaw_rate);
    rate_acc = int'(clamp_sym(rate_acc + rate_err, rate_lim));
    turn16 = (longint'(inner_kp) * rate_err + longint'(inner_ki) * rate_acc) >>> 12;
    if (turn16 >= DZ_MIN_TURN) turn16 += 16 * longint'(dz_counts);
    else if (turn16 <= -DZ_MIN_TURN) turn16 -= 16 * longint'(dz_counts);
    turn = turn16 >>> 4;
    w.left_pwm  = 11'(clamp_sym(longint'(base) - turn, pwm_lim));
    w.right_pwm = 11'(clamp_sym(longint'(base) + turn, pwm_lim));
    return w;
  endfunction

  always @(posedge clk) begin : watch
    wheel_word_t want;
    if (rst) begin
      outer_kp    = 16'd26829;
      outer_ki    = 16'd123;
      inner_kp    = 16'd1843;
      inner_ki    = 16'd102;
      angle_lim   = 4800;
      rate_lim    = 1280;
      dz_counts   = 16;
      pwm_lim     = 200;
      heading_acc = 0;
      rate_acc    = 0;
      wheel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cpyc_pkg::REG_OUTER_PROP: outer_kp  = cfg_data;
          cpyc_pkg::REG_OUTER_INT:  outer_ki  = cfg_data;
          cpyc_pkg::REG_INNER_PROP: inner_kp  = cfg_data;
          cpyc_pkg::REG_INNER_INT:  inner_ki  = cfg_data;
          cpyc_pkg::REG_ANGLE_LIM:  angle_lim = int'(cfg_data[14:0]);
          cpyc_pkg::REG_RATE_LIM:   rate_lim  = int'(cfg_data[14:0]);
          cpyc_pkg::REG_DEADZONE:   dz_counts = int'(cfg_data[7:0]);
          cpyc_pkg::REG_PWM_LIM:    pwm_lim   = int'(cfg_data[9:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        wheel_q.push_back(predict_wheels(fwd_speed, target_heading,
                                         measured_heading, measured_rate));
      if (out_valid && out_ready) begin
        if (wheel_q.size() == 0) begin
          bad_count++;
          $display("%0t: unexpected word left_pwm %0d right_pwm %0d", $time,
                   left_pwm, right_pwm);
        end else begin
          want = wheel_q.pop_front();
          good_count++;
          if (left_pwm !== want.left_pwm) begin
            bad_count++;
            $display("%0t: left_pwm expected %0d actual %0d", $time,
                     want.left_pwm, left_pwm);
          end
          if (right_pwm !== want.right_pwm) begin
            bad_count++;
            $display("%0t: right_pwm expected %0d actual %0d", $time,
                     want.right_pwm, right_pwm);
          end
        end
      end
    end
    mismatches    <= bad_count;
    outstanding   <= wheel_q.size();
    words_checked <= good_count;
  end

endmodule

/* dv/tb_cascaded_pi_yaw_controller_unit.sv */
// ----------------------------------------------------------------------------
// tb_cascaded_pi_yaw_controller_unit
// Stimulus and verdict for the cascaded PI yaw controller.
//
// A short directed run covers heading wrap, out-of-range headings, full-scale
// rates, small turns and zero/max register settings. Random sample words then
// run under twelve register settings and three idling mixes, with one long
// receiver hold-off; the checker module predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_cascaded_pi_yaw_controller_unit;

  localparam int HOLD_CYCLES       = 400;
  // one word in flight, plus the hold-off and long random gaps, with margin
  localparam int STALL_LIMIT       = 4000;
  localparam int SETTINGS_RUN      = 12;
  localparam int WORDS_PER_SETTING = 100;
  localparam int TAIL_CYCLES       = 100;

  typedef struct {
    logic [15:0] outer_kp;
    logic [15:0] outer_ki;
    logic [15:0] inner_kp;
    logic [15:0] inner_ki;
    logic [14:0] angle_lim;
    logic [14:0] rate_lim;
    logic [7:0]  dz_counts;
    logic [9:0]  pwm_lim;
  } gain_set_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic signed [10:0]               fwd_speed = '0;
  logic signed [12:0]               target_heading = '0;
  logic signed [12:0]               measured_heading = '0;
  logic signed [15:0]               measured_rate = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [10:0]               left_pwm;
  logic signed [10:0]               right_pwm;
  logic                             cfg_we = 1'b0;
  logic [cpyc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [cpyc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches, outstanding, words_checked;
  int words_sent = 0;
  int settings_loaded = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  cascaded_pi_yaw_controller_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .fwd_speed        (fwd_speed),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .measured_rate    (measured_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .left_pwm         (left_pwm),
    .right_pwm        (right_pwm),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cpyc_yaw_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .fwd_speed        (fwd_speed),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .measured_rate    (measured_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .left_pwm         (left_pwm),
    .right_pwm        (right_pwm),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .words_checked    (words_checked)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic signed [10:0] base,
                           input logic signed [12:0] tgt,
                           input logic signed [12:0] meas,
                           input logic signed [15:0] yaw_rate);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    fwd_speed        <= base;
    target_heading   <= tgt;
    measured_heading <= meas;
    measured_rate    <= yaw_rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_random();
    logic signed [12:0] tgt;
    logic signed [12:0] meas;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_word(11'($urandom), 13'($urandom), 13'($urandom), 16'($urandom));
    end else begin
      tgt = 13'(int'($urandom_range(5760)) - 2880);
      if (pick < 55) meas = 13'(int'($urandom_range(5760)) - 2880);
      else meas = 13'(int'(tgt) + int'($urandom_range(600)) - 300);
      send_word(11'(int'($urandom_range(2046)) - 1023), tgt, meas,
                16'(int'($urandom_range(4000)) - 2000));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // bits above the register width carry noise and must be dropped
  task automatic cfg_write(input cpyc_pkg::cfg_reg_t idx, input logic [15:0] val,
                           input int width);
    logic [15:0] noise;
    noise = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (noise & ~((16'(1) << width) - 16'(1))) | val;
    @(posedge clk);
  endtask

  task automatic load_gains(input gain_set_t g);
    cfg_write(cpyc_pkg::REG_OUTER_PROP, g.outer_kp, $bits(g.outer_kp));
    cfg_write(cpyc_pkg::REG_OUTER_INT, g.outer_ki, $bits(g.outer_ki));
    cfg_write(cpyc_pkg::REG_INNER_PROP, g.inner_kp, $bits(g.inner_kp));
    cfg_write(cpyc_pkg::REG_INNER_INT, g.inner_ki, $bits(g.inner_ki));
    cfg_write(cpyc_pkg::REG_ANGLE_LIM, 16'(g.angle_lim), $bits(g.angle_lim));
    cfg_write(cpyc_pkg::REG_RATE_LIM, 16'(g.rate_lim), $bits(g.rate_lim));
    cfg_write(cpyc_pkg::REG_DEADZONE, 16'(g.dz_counts), $bits(g.dz_counts));
    cfg_write(cpyc_pkg::REG_PWM_LIM, 16'(g.pwm_lim), $bits(g.pwm_lim));
    // unmapped index, ignored
    cfg_index <= cpyc_pkg::CFG_IDX_W'($urandom_range((1 << cpyc_pkg::CFG_IDX_W) - 1,
                                                     int'(cpyc_pkg::REG_PWM_LIM) + 1));
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic gain_set_t pick_setting(input int k);
    gain_set_t g;
    case (k % 4)
      0: begin
        g.outer_kp  = 16'($urandom_range(40000));
        g.outer_ki  = 16'($urandom_range(400));
        g.inner_kp  = 16'($urandom_range(4000));
        g.inner_ki  = 16'($urandom_range(300));
        g.angle_lim = 15'($urandom_range(8000));
        g.rate_lim  = 15'($urandom_range(3000));
        g.dz_counts = 8'($urandom_range(40));
        g.pwm_lim   = 10'($urandom_range(1023, 100));
      end
      1: begin
        g.outer_kp  = 16'($urandom);
        g.outer_ki  = 16'($urandom);
        g.inner_kp  = 16'($urandom);
        g.inner_ki  = 16'($urandom);
        g.angle_lim = 15'($urandom);
        g.rate_lim  = 15'($urandom);
        g.dz_counts = 8'($urandom);
        g.pwm_lim   = 10'($urandom);
      end
      2: begin
        case (k / 4)
          0: g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 8'hFF, 10'h3FF};
          1: g = '{16'h0, 16'h0, 16'h0, 16'h0, 15'h0, 15'h0, 8'h0, 10'h0};
          default: g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0, 15'h0, 8'hFF, 10'h3FF};
        endcase
      end
      default: g = '{16'd26829, 16'd123, 16'd1843, 16'd102, 15'd4800, 15'd1280, 8'd16, 10'd200};
    endcase
    return g;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    send_word(0, 0, 0, 0);
    send_word(1023, 2880, -2880, 0);
    send_word(-1024, -2880, 2880, 0);
    send_word(0, 4095, -4096, 0);
    send_word(0, -4096, 4095, 0);
    send_word(0, 2881, 0, 0);
    send_word(0, -2881, 0, 0);
    send_word(0, -2880, 0, 32767);
    send_word(0, 2880, 0, -32768);
    send_word(500, 0, 0, 3);
    send_word(-500, 0, 0, -3);
    send_word(0, 0, 0, 1);

    // integrators pinned at zero, no dead zone
    wait_drained();
    load_gains('{16'd26829, 16'd123, 16'd1843, 16'd102, 15'd0, 15'd0, 8'd0, 10'd1023});
    send_word(200, 100, 0, 0);
    send_word(-200, -100, 0, 0);
    send_word(0, 0, 0, -5);
    send_word(1023, 0, 0, 0);

    // everything at full scale
    wait_drained();
    load_gains('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 8'hFF, 10'h3FF});
    repeat (2) begin
      send_word(1023, 2880, -2880, 0);
      send_word(-1024, -2880, 0, 32767);
      send_word(1023, 2880, 0, -32768);
    end

    for (int k = 0; k < SETTINGS_RUN; k++) begin
      wait_drained();
      case (k / 4)
        0: begin
          send_idle = 20;
          recv_idle <= 80;
        end
        1: begin
          send_idle = 80;
          recv_idle <= 20;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      load_gains(pick_setting(k));
      if (k == 8) hold_req <= hold_req + 1;
      repeat (WORDS_PER_SETTING) send_random();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d sample words under %0d register settings; %0d result words checked.",
             words_sent, settings_loaded, words_checked);
    $display("Covered heading wrap, full-scale rates, zero and max limits,");
    $display("random stalls and a long receiver hold-off.");
    if (outstanding != 0)
      $display("%0t: %0d expected words never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
